// ===== rtl/bvp_pkg.sv =====
// Shared types and constants for the box versus path corridor hit block.
package bvp_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    localparam int BORDER_W     = 10;
    localparam int SIZE_W       = 10;
    localparam int BORDER_RESET = 17;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register select, taken from paddr[2]
    localparam logic REG_BORDER      = 1'b0;
    localparam logic REG_POINT_COUNT = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Compare results of one vertex against the grown query window
    typedef struct packed {
        logic x_le;
        logic x_ge;
        logic y_le;
        logic y_ge;
    } t_flags;

endpackage

// ===== rtl/box_vs_path_corridor_hit_top.sv =====
// Top level of the box versus path corridor hit block.
//
// Input channel (i_in_valid / o_in_stall) carries one item per transfer.
// cmd 0 writes vertex (x, y) into slot index; cmd 1 asks whether the box
// centered at (x, y) with the given width and height touches the path
// corridor. Every item gives exactly one result on the output channel
// (o_out_valid / i_out_stall); writes answer hit = 0.
// A write, or a query with fewer than two vertices, goes from its transfer to
// S_DONE and then to the output register; the next transfer waits for S_IDLE.
// A query walks the vertex table through its single read port, one vertex a
// cycle, over the first n vertices, then passes through S_DONE to the output
// register, n being point_count saturated at MAX_POINTS.
// One item is worked on at a time; o_in_stall is high while it is at work.
// The finished result sits in an output register, so a stalled receiver
// holds one result while the next item is taken; the block waits in its
// final step only when that register is full and the receiver stalls.
// Configuration registers (border at byte 0, point_count at byte 4) are written
// through the APB-style port; the user must write them only while the block is idle, as the block does not enforce it.
// Reset sets border to 17 and point_count to 0 and empties the output
// register; the vertex table is not cleared and holds garbage until written.
module box_vs_path_corridor_hit_top #(
    parameter int MAX_POINTS = bvp_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = bvp_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_in_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]         i_in_index,
    input  logic signed [COORD_BITS-1:0]          i_in_x,
    input  logic signed [COORD_BITS-1:0]          i_in_y,
    input  logic [bvp_pkg::SIZE_W-1:0]            i_in_width,
    input  logic [bvp_pkg::SIZE_W-1:0]            i_in_height,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_out_hit,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bvp_pkg::PADDR_W-1:0]           paddr,
    input  logic [bvp_pkg::PDATA_W-1:0]           pwdata,
    output logic [bvp_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready
);
    import bvp_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int PC_W  = $clog2(MAX_POINTS + 1);
    localparam int EXT_W = ((COORD_BITS > SIZE_W + 1) ? COORD_BITS : SIZE_W + 1) + 2;

    t_state                      r_state;
    logic [BORDER_W-1:0]         r_border;
    logic [PC_W-1:0]             r_point_count;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic                        r_acc;
    logic                        r_first;
    logic                        r_issue;
    logic                        r_data_vld;
    logic                        r_data_last;
    logic [IDX_W-1:0]            r_rd_addr;
    logic [IDX_W-1:0]            r_last_addr;
    logic [2*COORD_BITS-1:0]     r_rd_data;
    logic [2*COORD_BITS-1:0]     r_vtx_mem [MAX_POINTS];
    logic signed [EXT_W-1:0]     r_qx_hi, r_qx_lo, r_qy_hi, r_qy_lo;
    t_flags                      r_prev;

    logic                        w_in_xfer;
    logic                        w_out_free;
    logic                        w_cfg_wr;
    logic                        w_mem_wr;
    logic [PC_W-1:0]             w_n;
    logic signed [EXT_W-1:0]     w_x, w_y, w_mx, w_my;
    logic signed [EXT_W-1:0]     w_vx, w_vy;
    t_flags                      w_cur;
    logic                        w_seg;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_xfer   = i_in_valid & ~o_in_stall;
    assign w_out_free  = ~r_out_valid | ~i_out_stall;
    assign w_cfg_wr    = psel & penable & pwrite;
    assign pready      = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_hit   = r_out_hit;

    always_comb begin
        unique case (paddr[2])
            REG_BORDER:      prdata = PDATA_W'(r_border);
            REG_POINT_COUNT: prdata = PDATA_W'(r_point_count);
            default:         prdata = '0;
        endcase
    end

    // Count above table size saturates
    assign w_n = (r_point_count > PC_W'(MAX_POINTS)) ? PC_W'(MAX_POINTS) : r_point_count;

    // Fold the box half size and the border into one window per axis
    assign w_x  = EXT_W'(i_in_x);
    assign w_y  = EXT_W'(i_in_y);
    assign w_mx = $signed(EXT_W'(i_in_width >> 1)) + $signed(EXT_W'(r_border));
    assign w_my = $signed(EXT_W'(i_in_height >> 1)) + $signed(EXT_W'(r_border));

    // Shared compare unit: one vertex against the window each cycle
    assign w_vx = EXT_W'($signed(r_rd_data[COORD_BITS-1:0]));
    assign w_vy = EXT_W'($signed(r_rd_data[2*COORD_BITS-1:COORD_BITS]));

    always_comb begin
        w_cur.x_le = (w_vx <= r_qx_hi);
        w_cur.x_ge = (w_vx >= r_qx_lo);
        w_cur.y_le = (w_vy <= r_qy_hi);
        w_cur.y_ge = (w_vy >= r_qy_lo);
        w_seg = (w_cur.x_le | r_prev.x_le) & (w_cur.x_ge | r_prev.x_ge)
              & (w_cur.y_le | r_prev.y_le) & (w_cur.y_ge | r_prev.y_ge);
    end

    // Vertex table
    assign w_mem_wr = w_in_xfer & (i_in_cmd == CMD_WRITE)
                    & ((IDX_W + 1)'(i_in_index) < (IDX_W + 1)'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (w_mem_wr) begin
            r_vtx_mem[i_in_index] <= {i_in_y, i_in_x};
        end
        r_rd_data <= r_vtx_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_border      <= BORDER_W'(BORDER_RESET);
            r_point_count <= '0;
            r_out_valid   <= 1'b0;
            r_out_hit     <= 1'b0;
            r_acc         <= 1'b0;
            r_first       <= 1'b1;
            r_issue       <= 1'b0;
            r_data_vld    <= 1'b0;
            r_data_last   <= 1'b0;
            r_rd_addr     <= '0;
            r_last_addr   <= '0;
            r_prev        <= '0;
            r_qx_hi       <= '0;
            r_qx_lo       <= '0;
            r_qy_hi       <= '0;
            r_qy_lo       <= '0;
        end else begin
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_BORDER:      r_border      <= pwdata[BORDER_W-1:0];
                    REG_POINT_COUNT: r_point_count <= pwdata[PC_W-1:0];
                    default:         ;
                endcase
            end

            // Load the output register from the final step, else drain it on a transfer
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_acc   <= 1'b0;
                        r_qx_hi <= w_x + w_mx;
                        r_qx_lo <= w_x - w_mx;
                        r_qy_hi <= w_y + w_my;
                        r_qy_lo <= w_y - w_my;
                        if (i_in_cmd == CMD_QUERY && w_n >= PC_W'(2)) begin
                            r_state     <= S_RUN;
                            r_issue     <= 1'b1;
                            r_first     <= 1'b1;
                            r_data_vld  <= 1'b0;
                            r_rd_addr   <= '0;
                            r_last_addr <= IDX_W'(w_n - 1'b1);
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RUN: begin
                    if (r_issue) begin
                        r_rd_addr <= r_rd_addr + 1'b1;
                        if (r_rd_addr == r_last_addr) begin
                            r_issue <= 1'b0;
                        end
                    end
                    r_data_vld  <= r_issue;
                    r_data_last <= (r_rd_addr == r_last_addr);
                    if (r_data_vld) begin
                        r_prev  <= w_cur;
                        r_first <= 1'b0;
                        r_acc   <= r_acc | (~r_first & w_seg);
                        if (r_data_last) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // Hold the result until the output register frees up
                    if (w_out_free) begin
                        r_out_hit <= r_acc;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/bvp_chk.sv =====
// Port-level checker for the box versus path corridor hit block, with its bind.
module bvp_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_out_hit
);
    import bvp_pkg::*;

    // A held result stays until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_hit))
        else $error("output result dropped or changed while stalled");

    // Each accepted item holds o_in_stall high in the cycle after its transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

    // A new result appears only after the block was busy with an item
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item at work");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind box_vs_path_corridor_hit_top bvp_chk u_bvp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_hit   (o_out_hit)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the box versus path corridor hit block.
module tb;
    import bvp_pkg::*;

    localparam int NPTS        = MAX_POINTS_DEF;
    localparam int IDX_W       = $clog2(NPTS);
    localparam int LIMIT       = 1_000_000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 255;

    class hit_scoreboard;
        bit signed [COORD_BITS_DEF-1:0] path_x [NPTS];
        bit signed [COORD_BITS_DEF-1:0] path_y [NPTS];
        bit [BORDER_W-1:0] margin;
        bit [6:0] live_points;
        bit hits_due [$];
        int mismatches;

        function new();
            margin = BORDER_RESET;
            live_points = 0;
            mismatches = 0;
        endfunction

        function void flag(string what, int want, int got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        endfunction

        function void set_reg(logic sel, logic [PDATA_W-1:0] value);
            if (sel == REG_BORDER) begin
                margin = value[BORDER_W-1:0];
            end else begin
                live_points = value[6:0];
            end
        endfunction

        // Walk each segment of the path, grow its bounding box and test for contact
        function bit corridor_hit(int cx, int cy, int hw, int hh);
            int n, m, ax, ay, px, py, lox, hix, loy, hiy;
            n = (live_points > NPTS) ? NPTS : live_points;
            m = margin;
            for (int i = 1; i < n; i++) begin
                ax = path_x[i-1];
                ay = path_y[i-1];
                px = path_x[i];
                py = path_y[i];
                lox = ((ax < px) ? ax : px) - m;
                hix = ((ax < px) ? px : ax) + m;
                loy = ((ay < py) ? ay : py) - m;
                hiy = ((ay < py) ? py : ay) + m;
                if (lox <= cx + hw && hix >= cx - hw && loy <= cy + hh && hiy >= cy - hh)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_item(logic cmd, logic [IDX_W-1:0] idx,
                                logic signed [COORD_BITS_DEF-1:0] x,
                                logic signed [COORD_BITS_DEF-1:0] y,
                                logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
            if (cmd == CMD_WRITE) begin
                path_x[idx] = x;
                path_y[idx] = y;
                hits_due.push_back(1'b0);
            end else begin
                hits_due.push_back(corridor_hit(int'(x), int'(y),
                                                int'(w >> 1), int'(h >> 1)));
            end
        endfunction

        function void check_hit(logic got);
            bit want;
            if (hits_due.size() == 0) begin
                flag("unexpected result", -1, got);
            end else begin
                want = hits_due.pop_front();
                if (got !== want)
                    flag("hit", want, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_in_cmd = CMD_WRITE;
    logic [IDX_W-1:0] i_in_index = '0;
    logic signed [COORD_BITS_DEF-1:0] i_in_x = '0;
    logic signed [COORD_BITS_DEF-1:0] i_in_y = '0;
    logic [SIZE_W-1:0] i_in_width = '0;
    logic [SIZE_W-1:0] i_in_height = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_out_hit;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    hit_scoreboard sb = new();

    int cycles = 0;
    int stall_mode = 0;
    int stall_run = 0;
    int burst_left = 0;
    int base_x = 0;
    int base_y = 0;
    int margin_set [PHASES] = '{0, 1023, 17, -1, 1, -1, 1023};
    int count_set [PHASES]  = '{2, 64, 127, -1, 1, -1, 0};

    box_vs_path_corridor_hit_top u_top (.*);

    always #5 i_clk = ~i_clk;

    // Receiver: switch between no stall, scattered stalls and long stall runs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles % 300 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 9) < 4);
            default: begin
                if (stall_run == 0) begin
                    stall_run <= $urandom_range(1, 30);
                    i_out_stall <= ~i_out_stall;
                end else begin
                    stall_run <= stall_run - 1;
                end
            end
        endcase
        if (cycles >= LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_hit(o_out_hit);
            if (i_in_valid && !o_in_stall)
                sb.note_item(i_in_cmd, i_in_index, i_in_x, i_in_y, i_in_width, i_in_height);
        end
    end

    function automatic int clamp16(int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic int near(int c, int spread);
        return clamp16(c + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Present one item and hold it until the transfer
    task automatic send_item(logic cmd, logic [IDX_W-1:0] idx, int x, int y, int w, int h);
        i_in_valid <= 1'b1;
        i_in_cmd <= cmd;
        i_in_index <= idx;
        i_in_x <= x[COORD_BITS_DEF-1:0];
        i_in_y <= y[COORD_BITS_DEF-1:0];
        i_in_width <= w[SIZE_W-1:0];
        i_in_height <= h[SIZE_W-1:0];
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Drop valid and drain every pending result
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.hits_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic sel, int unsigned value);
        logic [PDATA_W-1:0] got, want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(sel, value);
        // read back at once
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        want = (sel == REG_BORDER) ? PDATA_W'(sb.margin) : PDATA_W'(sb.live_points);
        if (got !== want)
            sb.flag("register readback", want, got);
    endtask

    task automatic random_item();
        int r, n, slot, spread;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            send_item(CMD_WRITE, IDX_W'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else if (r < 25) begin
            send_item(CMD_WRITE, IDX_W'($urandom), near(base_x, 1500), near(base_y, 1500),
                      $urandom, $urandom);
        end else if (r < 40) begin
            send_item(CMD_QUERY, IDX_W'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else begin
            // aim near a live vertex so both hits and misses are common
            n = (sb.live_points > NPTS) ? NPTS : sb.live_points;
            slot = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, NPTS - 1);
            spread = sb.margin + 700;
            send_item(CMD_QUERY, IDX_W'($urandom), near(sb.path_x[slot], spread),
                      near(sb.path_y[slot], spread), $urandom, $urandom);
        end
    endtask

    initial begin
        base_x = int'($urandom_range(0, 56000)) - 28000;
        base_y = int'($urandom_range(0, 56000)) - 28000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty path answers no contact
        send_item(CMD_QUERY, '1, 32767, -32768, 1023, 1023);
        send_item(CMD_QUERY, '0, -32768, 32767, 0, 0);

        // load every slot so no query reads an unwritten vertex
        for (int s = 0; s < NPTS; s++) begin
            send_item(CMD_WRITE, IDX_W'(s), near(base_x, 1500), near(base_y, 1500), 0, 0);
            pace();
        end
        send_item(CMD_WRITE, 0, 0, 0, 0, 0);
        send_item(CMD_WRITE, 1, 100, 0, 0, 0);
        send_item(CMD_WRITE, 2, -32768, -32768, 1023, 1023);
        send_item(CMD_WRITE, 3, 32767, 32767, 0, 0);
        send_item(CMD_WRITE, IDX_W'(NPTS - 1), 32767, -32768, 1023, 1023);
        settle();

        // single vertex: no segment to hit
        write_reg(REG_POINT_COUNT, 1);
        send_item(CMD_QUERY, 0, 0, 0, 1023, 1023);
        settle();

        // touching and just-missing edges of segment (0,0)-(100,0) grown by 17
        write_reg(REG_POINT_COUNT, 2);
        send_item(CMD_QUERY, 0, 127, 0, 20, 0);
        send_item(CMD_QUERY, 0, 128, 0, 21, 0);
        send_item(CMD_QUERY, 0, -27, 0, 21, 1);
        send_item(CMD_QUERY, 0, -28, 0, 20, 0);
        send_item(CMD_QUERY, 0, 50, 22, 0, 10);
        send_item(CMD_QUERY, 0, 50, -23, 0, 11);
        settle();

        // coordinate and margin extremes
        write_reg(REG_BORDER, 1023);
        write_reg(REG_POINT_COUNT, 4);
        send_item(CMD_QUERY, IDX_W'(NPTS - 1), -32768, -32768, 0, 0);
        send_item(CMD_QUERY, 0, 32767, -32768, 1023, 1023);
        send_item(CMD_QUERY, 5, -32768, 32767, 1023, 0);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(REG_BORDER, (margin_set[p] < 0) ? $urandom_range(0, 1023) : margin_set[p]);
            write_reg(REG_POINT_COUNT,
                      (count_set[p] < 0) ? $urandom_range(0, 127) : count_set[p]);
            base_x = int'($urandom_range(0, 56000)) - 28000;
            base_y = int'($urandom_range(0, 56000)) - 28000;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                random_item();
                pace();
            end
        end

        settle();
        repeat (80) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bvp_pkg.sv
rtl/box_vs_path_corridor_hit_top.sv
rtl/bvp_chk.sv
verif/tb.sv
